FILE: sv/bhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bhs_pkg;

  localparam int KeyW = 64;
  localparam int StatusW = 3;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_CHECK  = 2'd1,
    FUNC_INDEX  = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_BAD_BIN   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_SEED     = 2'd0,
    REG_BINS     = 2'd1,
    REG_CAPACITY = 2'd2
  } reg_index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request and preset the hash state
    logic round;       // run one compression round
    logic finish;      // add the initial hash and start the reduction
    logic mod_step;    // one restoring-division bit of the reduction
    logic scan_issue;  // issue a slot read
    logic scan_check;  // compare the returned slot
    logic commit;      // write an inserted key and bump the fill
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic round_last;
    logic mod_last;
    logic scan_last;
    logic is_read;
  } dp_stat_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] v);
    bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

FILE: sv/bhs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bhs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/bhs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bhs_ctrl
  import bhs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output logic          busy,
  input  wire logic     clr_active,
  output dp_cmd_t       cmd,
  output logic          done
);
  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_FIN, S_MOD, S_ISSUE, S_SCAN, S_COMMIT, S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            state <= stat.is_read ? S_ISSUE : S_HASH;
          end
        end
        S_HASH:   if (stat.round_last) state <= S_FIN;
        S_FIN:    state <= S_MOD;
        S_MOD:    if (stat.mod_last) state <= S_ISSUE;
        S_ISSUE:  state <= S_SCAN;
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_COMMIT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_COMMIT: state <= S_DONE;
        S_DONE:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && start && !busy;
    cmd.round = (state == S_HASH);
    cmd.finish = (state == S_FIN);
    cmd.mod_step = (state == S_MOD);
    cmd.scan_issue = (state == S_ISSUE) || (state == S_SCAN);
    cmd.scan_check = (state == S_SCAN);
    cmd.commit = (state == S_COMMIT);
    busy = (state != S_IDLE) || clr_active;
    done = (state == S_DONE);
  end
endmodule
`default_nettype wire

FILE: sv/bhs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bhs_datapath
  import bhs_pkg::*;
#(
  parameter int NumBins = 1024,
  parameter int MaxLoad = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic [1:0]  func,
  input  wire logic [63:0] key,
  input  wire logic [9:0]  bin_select,
  input  wire logic [3:0]  slot_select,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  output logic             clr_active,
  output logic [2:0]       status,
  output logic             found,
  output logic [9:0]       bin_index,
  output logic [63:0]      entry_value,
  output logic [4:0]       bin_fill
);
  localparam int BinW = $clog2(NumBins);
  localparam int SlotW = (MaxLoad > 1) ? $clog2(MaxLoad) : 1;
  localparam int CntW = $clog2(MaxLoad + 1);
  localparam int ModW = BinW + 1;

  // Configuration.
  logic [63:0] hash_seed;
  logic [10:0] bins_in_use;
  logic [4:0]  bin_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= 64'd1;
      bins_in_use <= 11'd1024;
      bin_capacity <= 5'd5;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SEED:     hash_seed <= cfg_data;
        REG_BINS:     bins_in_use <= cfg_data[10:0];
        REG_CAPACITY: bin_capacity <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [16:0] eff_bins;
  logic [6:0]  eff_cap;
  always_comb begin
    if (bins_in_use == 11'd0) eff_bins = 17'd1;
    else if (17'(bins_in_use) > 17'(NumBins)) eff_bins = 17'(NumBins);
    else eff_bins = 17'(bins_in_use);
    eff_cap = (7'(bin_capacity) > 7'(MaxLoad)) ? 7'(MaxLoad) : 7'(bin_capacity);
  end

  // Request capture.
  logic [1:0]       req_func;
  logic [63:0]      req_key;
  logic [BinW-1:0]  req_bin;
  logic [3:0]       req_slot;
  logic             req_bad_bin;

  // SHA-256 round engine with a 16-word rolling schedule.
  logic [31:0] sa, sb, sc, sd, se, sf, sg, sh;
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic [31:0] s0, s1, w_new, t1, t2;

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    t1 = sh + (rotr(se, 6) ^ rotr(se, 11) ^ rotr(se, 25)) + ((se & sf) ^ (~se & sg))
         + RoundK[rnd] + w[0];
    t2 = (rotr(sa, 2) ^ rotr(sa, 13) ^ rotr(sa, 22)) + ((sa & sb) ^ (sa & sc) ^ (sb & sc));
  end

  // Reduction: restoring division, one quotient bit per cycle.
  logic [63:0]     dividend;
  logic [ModW-1:0] rem;
  logic [6:0]      mod_cnt;
  logic [ModW:0]   rem_shift;
  assign rem_shift = {rem, dividend[63]};

  // Scan.
  logic [CntW-1:0] fill;
  logic [4:0]      scan_idx;
  logic [4:0]      chk_idx;
  logic            hit;
  logic [63:0]     ram_rdata;
  logic [4:0]      cnt_rdata;
  logic            cnt_valid_q;

  // Fill counters: RAM plus a clearing sweep after reset.
  logic [BinW-1:0] clr_addr;
  logic [BinW-1:0] cur_bin;
  assign cur_bin = req_bin;

  logic            cnt_we;
  logic [BinW-1:0] cnt_waddr;
  logic [4:0]      cnt_wdata;
  assign cnt_we = clr_active || (cmd.commit && req_func == FUNC_INSERT && !hit
                                 && 7'(fill) < eff_cap);
  assign cnt_waddr = clr_active ? clr_addr : cur_bin;
  assign cnt_wdata = clr_active ? 5'd0 : 5'(fill + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (32'(clr_addr) == NumBins - 1) clr_active <= 1'b0;
    end
  end

  bhs_ram #(.Width(5), .Depth(NumBins)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cur_bin), .rdata(cnt_rdata)
  );

  logic                   ent_we;
  logic [BinW+SlotW-1:0]  ent_waddr, ent_raddr;
  logic [SlotW-1:0]       rd_slot;
  assign rd_slot = (req_func == FUNC_READ) ? SlotW'(req_slot) : SlotW'(scan_idx);
  assign ent_we = cnt_we && !clr_active;
  assign ent_waddr = {cur_bin, SlotW'(fill)};
  assign ent_raddr = {cur_bin, rd_slot};

  bhs_ram #(.Width(64), .Depth(NumBins * MaxLoad)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(req_key),
    .raddr(ent_raddr), .rdata(ram_rdata)
  );

  assign stat.round_last = (rnd == 6'd63);
  assign stat.mod_last = (mod_cnt == 7'd63);
  assign stat.scan_last = cnt_valid_q && (5'(chk_idx) + 5'd1 >= 5'(fill)
                          || req_func == FUNC_READ || req_func == FUNC_INDEX
                          || fill == '0);
  assign stat.is_read = (func == FUNC_READ);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func <= func;
      req_key <= key;
      req_slot <= slot_select;
      req_bin <= BinW'(bin_select);
      req_bad_bin <= (17'(bin_select) >= eff_bins);
      sa <= StartH[0]; sb <= StartH[1]; sc <= StartH[2]; sd <= StartH[3];
      se <= StartH[4]; sf <= StartH[5]; sg <= StartH[6]; sh <= StartH[7];
      w[0] <= bswap(hash_seed[31:0]);
      w[1] <= bswap(hash_seed[63:32]);
      w[2] <= bswap(key[31:0]);
      w[3] <= bswap(key[63:32]);
      w[4] <= 32'h80000000;
      for (int i = 5; i < 15; i++) w[i] <= 32'd0;
      w[15] <= 32'd128;
      rnd <= 6'd0;
    end else if (cmd.round) begin
      sh <= sg; sg <= sf; sf <= se; se <= sd + t1;
      sd <= sc; sc <= sb; sb <= sa; sa <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= w_new;
      rnd <= rnd + 6'd1;
    end else if (cmd.finish) begin
      // Digest words 0 and 1, bytes taken little-endian.
      dividend <= {bswap(sb + StartH[1]), bswap(sa + StartH[0])};
      rem <= '0;
      mod_cnt <= 7'd0;
    end else if (cmd.mod_step) begin
      if ((ModW + 1)'(rem_shift) >= (ModW + 1)'(eff_bins)) begin
        rem <= ModW'(rem_shift - (ModW + 1)'(eff_bins));
      end else begin
        rem <= ModW'(rem_shift);
      end
      dividend <= {dividend[62:0], 1'b0};
      mod_cnt <= mod_cnt + 7'd1;
      if (mod_cnt == 7'd63) begin
        if ((ModW + 1)'(rem_shift) >= (ModW + 1)'(eff_bins)) begin
          req_bin <= BinW'(rem_shift - (ModW + 1)'(eff_bins));
        end else begin
          req_bin <= BinW'(rem_shift);
        end
      end
    end
  end

  // Slot scan: the fill and slot 0 are fetched first, then each slot read is
  // issued in the cycle before its compare.
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.mod_step) begin
      scan_idx <= '0;
      chk_idx <= '0;
      hit <= 1'b0;
      cnt_valid_q <= 1'b0;
    end else if (cmd.scan_issue) begin
      if (cmd.scan_check) begin
        scan_idx <= scan_idx + 5'd1;
      end
      if (!cmd.scan_check) begin
        cnt_valid_q <= 1'b0;
      end else if (!cnt_valid_q) begin
        cnt_valid_q <= 1'b1;
        fill <= CntW'(cnt_rdata);
      end else begin
        chk_idx <= chk_idx + 5'd1;
      end
      if (cmd.scan_check && cnt_valid_q && 5'(chk_idx) < 5'(fill)
          && ram_rdata == req_key && !hit) begin
        hit <= 1'b1;
      end
    end
    // The entry register holds the read slot only when it is valid.
    if (cmd.commit) begin
      entry_value <= (req_func == FUNC_READ && !req_bad_bin && 5'(req_slot) < 5'(fill))
                     ? ram_rdata : 64'd0;
    end
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      bin_index <= 10'(req_bin);
      found <= 1'b0;
      status <= ST_OK;
      bin_fill <= 5'(fill);
      unique case (func_t'(req_func))
        FUNC_INSERT: begin
          if (hit) begin
            status <= ST_DUPLICATE;
            found <= 1'b1;
          end else if (7'(fill) >= eff_cap) begin
            status <= ST_OVERFLOW;
          end else begin
            found <= 1'b1;
            bin_fill <= 5'(fill + 1'b1);
          end
        end
        FUNC_CHECK: found <= hit;
        FUNC_INDEX: ;
        FUNC_READ: begin
          bin_index <= 10'(req_bin);
          if (req_bad_bin) begin
            status <= ST_BAD_BIN;
            bin_fill <= 5'd0;
          end else if (5'(req_slot) >= 5'(fill)) begin
            status <= ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/binned_hash_set_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Binned hash set of 64-bit keys. A request is taken when start is high and
// busy is low; its single result appears for one cycle with done high and
// cannot be held off. Hash requests (insert, check, bin index) run 64 SHA-256
// rounds, a finishing state, 64 division steps, an issue state, a slot scan
// that fetches the fill and then compares each stored key (bin index
// compares none), and a commit state. A read skips the rounds and the
// reduction and goes straight to the issue, scan and commit states.
// Busy falls in the cycle after done, so a new request is taken only once the
// previous one has finished. The round engine and the bit-serial reduction
// take up most of a hash request. After reset the fill counters are swept to
// zero, one bin per cycle, with busy held high.
// Configuration must be written only while no request is in flight.
module binned_hash_set_core
  import bhs_pkg::*;
#(
  parameter int NumBins = 1024,
  parameter int MaxLoad = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [63:0] key,
  input  wire logic [9:0]  bin_select,
  input  wire logic [3:0]  slot_select,
  output logic             done,
  output logic [2:0]       status,
  output logic             found,
  output logic [9:0]       bin_index,
  output logic [63:0]      entry_value,
  output logic [4:0]       bin_fill
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     clr_active;

  bhs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .busy(busy),
    .clr_active(clr_active), .cmd(cmd), .done(done)
  );

  bhs_datapath #(.NumBins(NumBins), .MaxLoad(MaxLoad)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .func(func), .key(key), .bin_select(bin_select),
    .slot_select(slot_select), .cmd(cmd), .stat(stat), .clr_active(clr_active),
    .status(status), .found(found), .bin_index(bin_index),
    .entry_value(entry_value), .bin_fill(bin_fill)
  );
endmodule
`default_nettype wire

FILE: sv/bhs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bhs_checker
  import bhs_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [2:0] status,
  input wire logic       found
);
  // A result only follows a request in flight.
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without a request");
  // A request is not taken twice in a row.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy did not rise");
  // Results come one at a time.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double result");
  // A duplicate insert always reports the key as present.
  assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DUPLICATE) |-> found)
    else $error("duplicate without found");
endmodule

bind binned_hash_set_core bhs_checker u_bhs_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .found(found)
);
`default_nettype wire
